/* src/dtt_pkg.sv */
// Shared types and codes for the deadline timer table.
package dtt_pkg;

	localparam int TIMER_SLOTS_DEF = 32;

	localparam logic OP_ARM  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic        [11:0] task_id;
		logic signed [31:0] delay_val;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  arm_status;
		logic [11:0] fired_task;
		logic [30:0] fired_value;
		logic        last_of_run;
	} result_t;

endpackage

/* src/deadline_timer_table_top.sv */
// Top level of the deadline timer table: slot memory, scan sequencer and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------
//  command  | start, busy          | cmd    (cmd_t)
//  result   | strobe               | result (result_t)
//
// An arm transaction leaves busy low; its status appears on the next cycle.
// A tick transaction holds busy while the scan runs: the slot memory has one read
// port, so the scan reads one slot per cycle, then drains the read stage and flushes the
// last fired result. Each fired result waits in a holding register until the next hit or
// the flush; the last one appears in the first cycle with busy low. Results are never held off.
// Reset clears the counter, the active bits and the sequencer; slot contents are left as is.
module deadline_timer_table_top #(
	parameter int TIMER_SLOTS = dtt_pkg::TIMER_SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dtt_pkg::cmd_t   cmd,
	output logic            strobe,
	output dtt_pkg::result_t result
);
	import dtt_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	typedef struct packed {
		logic [11:0] task_id;
		logic [31:0] deadline;
		logic [30:0] delay;
	} slot_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FLUSH
	} state_t;

	slot_t                  mem [TIMER_SLOTS];
	state_t                 state_q;
	logic [IW-1:0]          idx_q;
	logic [31:0]            now_q;
	logic [TIMER_SLOTS-1:0] active_q;
	logic                   vld_s1;
	logic [IW-1:0]          idx_s1;
	slot_t                  rd_s1;
	logic                   strobe_q;
	result_t                result_q;
	logic                   pend_vld_q;
	result_t                pend_q;

	logic          accept;
	logic          arm_acc;
	logic          tick_acc;
	logic          arm_bad;
	logic          have_free;
	logic [IW-1:0] free_idx;
	logic          arm_ok;
	logic [31:0]   diff;
	logic          hit;
	logic          flush;
	slot_t         wr_entry;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign arm_acc  = accept && (cmd.opcode == OP_ARM);
	assign tick_acc = accept && (cmd.opcode == OP_TICK);
	assign arm_bad  = (cmd.task_id == 12'd0) || cmd.delay_val[31];
	assign arm_ok   = arm_acc && !arm_bad && have_free;
	assign diff     = now_q - rd_s1.deadline;
	assign hit      = vld_s1 && active_q[idx_s1] && !diff[31];
	assign flush    = (state_q == S_FLUSH);

	assign wr_entry.task_id  = cmd.task_id;
	assign wr_entry.deadline = now_q + unsigned'(cmd.delay_val);
	assign wr_entry.delay    = cmd.delay_val[30:0];

	// find the lowest free slot
	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				have_free = 1'b1;
				free_idx  = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arm_ok) begin
			mem[free_idx] <= wr_entry;
		end
		rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			now_q      <= '0;
			active_q   <= '0;
			vld_s1     <= 1'b0;
			strobe_q   <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			vld_s1   <= (state_q == S_SCAN);
			strobe_q <= arm_acc || ((hit || flush) && pend_vld_q);
			if (hit) begin
				pend_vld_q       <= 1'b1;
				active_q[idx_s1] <= 1'b0;
			end else if (flush) begin
				pend_vld_q <= 1'b0;
			end
			if (arm_ok) begin
				active_q[free_idx] <= 1'b1;
			end
			if (tick_acc) begin
				now_q <= now_q + 32'd1;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (tick_acc) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == IW'(TIMER_SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FLUSH;
				S_FLUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (arm_acc) begin
			result_q.result_kind <= KIND_STATUS;
			result_q.arm_status  <= arm_bad ? ST_INVALID : (have_free ? ST_OK : ST_FULL);
			result_q.fired_task  <= '0;
			result_q.fired_value <= '0;
			result_q.last_of_run <= 1'b1;
		end else if (hit) begin
			result_q <= pend_q;
		end else if (flush) begin
			result_q.result_kind <= pend_q.result_kind;
			result_q.arm_status  <= pend_q.arm_status;
			result_q.fired_task  <= pend_q.fired_task;
			result_q.fired_value <= pend_q.fired_value;
			result_q.last_of_run <= 1'b1;
		end
		if (hit) begin
			pend_q.result_kind <= KIND_FIRED;
			pend_q.arm_status  <= ST_OK;
			pend_q.fired_task  <= rd_s1.task_id;
			pend_q.fired_value <= rd_s1.delay;
			pend_q.last_of_run <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_fired_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_FIRED) |-> $past(busy))
		else $error("fired result outside a scan");

	a_arm_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_STATUS) |-> result.last_of_run)
		else $error("arm status not marked last");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.opcode == OP_TICK) |=> busy)
		else $error("tick did not start a scan");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> $stable(active_q) && $stable(now_q))
		else $error("slot state changed while idle");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |=> !pend_vld_q && (state_q == S_IDLE))
		else $error("pending result survived the flush");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the deadline timer table: arm and tick transactions against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import dtt_pkg::*;

	localparam int SLOTS = TIMER_SLOTS_DEF;
	localparam int MAX_ERR_LOG = 10;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    strobe;
	result_t result;

	result_t     pending_results[$];
	logic        slot_on[SLOTS];
	logic [11:0] slot_task_id[SLOTS];
	logic [31:0] slot_due[SLOTS];
	logic [30:0] slot_span[SLOTS];
	logic [31:0] now_ms;
	bit          idle_on;
	int          errors;
	int          n_arm_ok, n_arm_bad, n_arm_full, n_ticks, n_fired;

	deadline_timer_table_top #(.TIMER_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic log_failure(input string msg);
		errors++;
		if (errors <= MAX_ERR_LOG) $display("%0t: %s", $realtime, msg);
	endtask

	// Advance the table for one accepted transaction and queue what it must produce.
	task automatic model_timer_table(input cmd_t c);
		result_t     r;
		result_t     prev;
		bit          have_prev;
		logic [31:0] lag;
		int          idx;
		int          i;
		r = '0;
		have_prev = 1'b0;
		if (c.opcode == OP_ARM) begin
			r.result_kind = KIND_STATUS;
			r.last_of_run = 1'b1;
			if (c.task_id == 12'd0 || c.delay_val[31]) begin
				r.arm_status = ST_INVALID;
				n_arm_bad++;
			end else begin
				idx = -1;
				for (i = 0; i < SLOTS; i++)
					if (!slot_on[i] && idx < 0) idx = i;
				if (idx < 0) begin
					r.arm_status = ST_FULL;
					n_arm_full++;
				end else begin
					slot_on[idx] = 1'b1;
					slot_task_id[idx] = c.task_id;
					slot_due[idx] = now_ms + c.delay_val;
					slot_span[idx] = c.delay_val[30:0];
					r.arm_status = ST_OK;
					n_arm_ok++;
				end
			end
			pending_results.push_back(r);
		end else begin
			n_ticks++;
			now_ms = now_ms + 32'd1;
			for (i = 0; i < SLOTS; i++) begin
				if (slot_on[i]) begin
					lag = now_ms - slot_due[i];
					if (!lag[31]) begin
						slot_on[i] = 1'b0;
						if (have_prev) pending_results.push_back(prev);
						prev = '0;
						prev.result_kind = KIND_FIRED;
						prev.arm_status = ST_OK;
						prev.fired_task = slot_task_id[i];
						prev.fired_value = slot_span[i];
						have_prev = 1'b1;
						n_fired++;
					end
				end
			end
			if (have_prev) begin
				prev.last_of_run = 1'b1;
				pending_results.push_back(prev);
			end
		end
	endtask

	function automatic int pick_gap();
		int x;
		x = $urandom_range(0, 99);
		if (!idle_on || x < 55) return 0;
		if (x < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_cmd(input logic op, input logic [11:0] tid, input logic [31:0] dly);
		cmd_t c;
		int   g;
		c.opcode = op;
		c.task_id = tid;
		c.delay_val = dly;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		model_timer_table(c);
		g = pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_cmd(OP_TICK, 12'($urandom), $urandom);
	endtask

	// Tick until every short timer has fired; the long-lived ones stay armed.
	task automatic tick_until_quiet();
		logic [31:0] lag;
		bit          due_soon;
		int          i;
		do begin
			due_soon = 1'b0;
			for (i = 0; i < SLOTS; i++) begin
				lag = slot_due[i] - now_ms;
				if (slot_on[i] && !lag[31] && lag < 32'd1000) due_soon = 1'b1;
			end
			if (due_soon) send_tick();
		end while (due_soon);
	endtask

	task automatic test_rejects();
		send_cmd(OP_ARM, 12'd0, 32'd5);
		send_cmd(OP_ARM, 12'd0, 32'd0);
		send_cmd(OP_ARM, 12'd7, 32'hFFFF_FFFF);
		send_cmd(OP_ARM, 12'hFFF, 32'h8000_0000);
		send_cmd(OP_ARM, 12'd0, 32'hA5A5_5A5A);
	endtask

	task automatic test_quiet_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_extremes_and_bursts();
		send_cmd(OP_ARM, 12'hFFF, 32'h7FFF_FFFF);
		send_cmd(OP_ARM, 12'hAAA, 32'h4000_0000);
		send_cmd(OP_ARM, 12'd1, 32'd0);
		send_tick();
		send_cmd(OP_ARM, 12'h555, 32'd3);
		send_cmd(OP_ARM, 12'h800, 32'd3);
		send_cmd(OP_ARM, 12'h001, 32'd1);
		send_cmd(OP_ARM, 12'h7FF, 32'd3);
		tick_until_quiet();
	endtask

	task automatic test_full_table();
		int free_slots;
		int i;
		free_slots = 0;
		for (i = 0; i < SLOTS; i++)
			if (!slot_on[i]) free_slots++;
		for (i = 0; i <= free_slots; i++)
			send_cmd(OP_ARM, 12'($urandom_range(1, 4095)), 32'($urandom_range(0, 3)));
		tick_until_quiet();
	endtask

	task automatic test_random_traffic(input int n_items);
		int arm_pct;
		int x;
		int i;
		arm_pct = 50;
		for (i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				idle_on = $urandom_range(0, 2) != 0;
				arm_pct = $urandom_range(30, 70);
			end
			x = $urandom_range(0, 99);
			if (x >= arm_pct) begin
				send_tick();
			end else if (x < arm_pct / 8) begin
				if ($urandom_range(0, 1) != 0)
					send_cmd(OP_ARM, 12'd0, $urandom);
				else
					send_cmd(OP_ARM, 12'($urandom), $urandom | 32'h8000_0000);
			end else if (x == arm_pct / 8) begin
				send_cmd(OP_ARM, 12'($urandom_range(1, 4095)),
					32'($urandom_range(1000, 100000)));
			end else begin
				send_cmd(OP_ARM, 12'($urandom_range(1, 4095)),
					32'($urandom_range(0, 40)));
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t e;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				log_failure($sformatf("unexpected result %p", result));
			end else begin
				e = pending_results.pop_front();
				if (result.result_kind !== e.result_kind || result.arm_status !== e.arm_status
					|| result.fired_task !== e.fired_task
					|| result.fired_value !== e.fired_value
					|| result.last_of_run !== e.last_of_run)
					log_failure($sformatf("mismatch: expected %p, got %p", e, result));
			end
		end
	end

	initial begin
		int i;
		errors = 0;
		now_ms = '0;
		idle_on = 1'b1;
		n_arm_ok = 0;
		n_arm_bad = 0;
		n_arm_full = 0;
		n_ticks = 0;
		n_fired = 0;
		for (i = 0; i < SLOTS; i++) begin
			slot_on[i] = 1'b0;
			slot_task_id[i] = '0;
			slot_due[i] = '0;
			slot_span[i] = '0;
		end
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejects();
		test_quiet_tick();
		test_extremes_and_bursts();
		test_full_table();
		test_random_traffic(250);

		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		repeat (SLOTS + 8) @(posedge clk);
		if (pending_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", pending_results.size()));

		$display("Arms: %0d accepted, %0d rejected, %0d refused with the table full",
			n_arm_ok, n_arm_bad, n_arm_full);
		$display("Ticks: %0d, timers fired: %0d, mismatches: %0d", n_ticks, n_fired, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
